// ----- sv/playfair_digraph_cipher_top_macros.svh -----
// Assertion macros used by the top module of the cipher block.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pf_pkg.sv -----
`default_nettype none
package pf_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    localparam logic [4:0] IDX_J  = 5'd9;
    localparam logic [4:0] IDX_X  = 5'd23;
    localparam logic [6:0] CHAR_A = 7'd65;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_KEY    = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;
    localparam logic [1:0] OP_CIPHER = 2'd3;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_loc;

    typedef struct packed {
        logic       en;
        logic [4:0] letter;
        logic [4:0] slot;
    } t_place;

    typedef struct packed {
        logic [4:0] first;
        logic [4:0] second;
    } t_pair;

    function automatic logic [4:0] letter_index(input logic [7:0] c);
        logic [4:0] idx;
        idx = 5'(LETTERS);
        if (c >= 8'd97 && c <= 8'd122) begin
            idx = 5'(c - 8'd97);
        end else if (c >= 8'd65 && c <= 8'd90) begin
            idx = 5'(c - 8'd65);
        end
        return idx;
    endfunction

    function automatic t_loc pos_to_loc(input logic [4:0] p);
        t_loc       l;
        logic [4:0] base;
        if (p >= 5'd20) begin
            l.row = 3'd4;
        end else if (p >= 5'd15) begin
            l.row = 3'd3;
        end else if (p >= 5'd10) begin
            l.row = 3'd2;
        end else if (p >= 5'd5) begin
            l.row = 3'd1;
        end else begin
            l.row = 3'd0;
        end
        base  = 5'({2'b00, l.row} << 2) + {2'b00, l.row};
        l.col = 3'(p - base);
        return l;
    endfunction

    function automatic logic [4:0] loc_to_cell(input t_loc l);
        return 5'({2'b00, l.row} << 2) + {2'b00, l.row} + {2'b00, l.col};
    endfunction

    function automatic logic [2:0] step_mod5(input logic [2:0] v, input logic dec);
        logic [2:0] r;
        if (dec) begin
            r = (v == 3'd0) ? 3'(SIDE - 1) : 3'(v - 3'd1);
        end else begin
            r = (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
        end
        return r;
    endfunction

    function automatic logic [4:0] square_reset(input logic [4:0] slot);
        return (slot < IDX_J) ? slot : 5'(slot + 5'd1);
    endfunction

    function automatic logic [4:0] position_reset(input logic [4:0] letter);
        logic [4:0] r;
        if (letter < IDX_J) begin
            r = letter;
        end else if (letter == IDX_J) begin
            r = 5'd0;
        end else begin
            r = 5'(letter - 5'd1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/pf_in_if.sv -----
`default_nettype none
interface pf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       has_second;

    modport source (
        output valid, opcode, first_char, second_char, has_second,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_char, second_char, has_second,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/pf_out_if.sv -----
`default_nettype none
interface pf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] first_out;
    logic [6:0] second_out;
    logic       bad_letter;

    modport source (
        output valid, first_out, second_out, bad_letter,
        input  ready
    );

    modport sink (
        input  valid, first_out, second_out, bad_letter,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/pf_lane.sv -----
`default_nettype none
module pf_lane (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [4:0]           i_letter,
    input  wire logic [25:0]          i_used,
    input  wire logic                 i_rd_en,
    input  wire pf_pkg::t_place       i_place,
    output logic                      o_present,
    output pf_pkg::t_loc              o_loc
);

    logic [4:0]  r_mem [pf_pkg::LETTERS];
    logic [25:0] r_vld;
    logic [4:0]  r_pos;

    always_ff @(posedge i_clk) begin
        if (i_place.en) begin
            r_mem[i_place.letter] <= i_place.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_place.en) begin
            r_vld[i_place.letter] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_letter < 5'(pf_pkg::LETTERS)) begin
                r_pos <= r_vld[i_letter] ? r_mem[i_letter]
                                         : pf_pkg::position_reset(i_letter);
            end else begin
                r_pos <= '0;
            end
        end
    end

    assign o_present = (i_letter < 5'(pf_pkg::LETTERS)) && (i_letter != pf_pkg::IDX_J)
                       && i_used[i_letter];
    assign o_loc = pf_pkg::pos_to_loc(r_pos);

endmodule
`default_nettype wire

// ----- sv/pf_merge.sv -----
`default_nettype none
module pf_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pf_pkg::t_loc         i_loc_a,
    input  wire pf_pkg::t_loc         i_loc_b,
    input  wire logic                 i_decrypt,
    input  wire logic                 i_rd_en,
    input  wire pf_pkg::t_place       i_place,
    output pf_pkg::t_pair             o_pair
);

    logic [4:0]   r_mem [pf_pkg::CELLS];
    logic [24:0]  r_vld;
    pf_pkg::t_loc out_a;
    pf_pkg::t_loc out_b;
    logic [4:0]   cell_a;
    logic [4:0]   cell_b;

    always_comb begin
        if (i_loc_a.row == i_loc_b.row) begin
            out_a.row = i_loc_a.row;
            out_a.col = pf_pkg::step_mod5(i_loc_a.col, i_decrypt);
            out_b.row = i_loc_b.row;
            out_b.col = pf_pkg::step_mod5(i_loc_b.col, i_decrypt);
        end else if (i_loc_a.col == i_loc_b.col) begin
            out_a.row = pf_pkg::step_mod5(i_loc_a.row, i_decrypt);
            out_a.col = i_loc_a.col;
            out_b.row = pf_pkg::step_mod5(i_loc_b.row, i_decrypt);
            out_b.col = i_loc_b.col;
        end else begin
            out_a.row = i_loc_a.row;
            out_a.col = i_loc_b.col;
            out_b.row = i_loc_b.row;
            out_b.col = i_loc_a.col;
        end
    end

    assign cell_a = pf_pkg::loc_to_cell(out_a);
    assign cell_b = pf_pkg::loc_to_cell(out_b);

    always_ff @(posedge i_clk) begin
        if (i_place.en) begin
            r_mem[i_place.slot] <= i_place.letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_place.en) begin
            r_vld[i_place.slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_pair.first  <= r_vld[cell_a] ? r_mem[cell_a] : pf_pkg::square_reset(cell_a);
            o_pair.second <= r_vld[cell_b] ? r_mem[cell_b] : pf_pkg::square_reset(cell_b);
        end
    end

endmodule
`default_nettype wire

// ----- sv/playfair_digraph_cipher_top.sv -----
// Playfair cipher on a 5x5 key square without J. Clear and key-byte items are taken
// in the idle state. A finish-fill item walks all 26 letters, one per cycle. For a
// digraph, two lanes look up the positions of both letters in their letter maps in
// one registered read, and the merge stage applies the row, column or rectangle rule
// and reads both result cells from the key square in a second registered read. The
// result then sits in an output register, so the next item is taken while it waits
// for transfer. After reset the square holds the alphabet in order and is ready at
// once; no clearing pass is run.
`default_nettype none
`include "playfair_digraph_cipher_top_macros.svh"
module playfair_digraph_cipher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    pf_in_if.sink     i_in,
    pf_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POS  = 2'd1;
    localparam logic [1:0] S_CELL = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    logic [4:0]     r_fill;
    logic [4:0]     r_walk;
    logic [25:0]    r_used;
    logic           r_decrypt;
    logic           r_err;
    logic           r_out_valid;
    logic [6:0]     r_out_first;
    logic [6:0]     r_out_second;
    logic           r_out_bad;

    logic           in_fire;
    logic           lookup_en;
    logic           load;
    logic [4:0]     letter_a;
    logic [4:0]     letter_b_raw;
    logic [4:0]     letter_b;
    logic           present_a;
    logic           present_b;
    pf_pkg::t_loc   loc_a;
    pf_pkg::t_loc   loc_b;
    pf_pkg::t_pair  pair;
    pf_pkg::t_place place;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign lookup_en  = in_fire && (i_in.opcode == pf_pkg::OP_CIPHER);
    assign load       = (r_state == S_CELL) && (!r_out_valid || o_out.ready);

    assign letter_a     = pf_pkg::letter_index(i_in.first_char);
    assign letter_b_raw = i_in.has_second ? pf_pkg::letter_index(i_in.second_char)
                                          : pf_pkg::IDX_X;
    assign letter_b     = (letter_b_raw == letter_a) ? pf_pkg::IDX_X : letter_b_raw;

    always_comb begin
        place.en     = 1'b0;
        place.letter = letter_a;
        place.slot   = r_fill;
        if (r_state == S_FILL) begin
            place.letter = r_walk;
            place.en     = !r_used[r_walk] && (r_fill < 5'(pf_pkg::CELLS));
        end else if (in_fire && (i_in.opcode == pf_pkg::OP_KEY)) begin
            if (letter_a < 5'(pf_pkg::LETTERS)) begin
                place.en = !r_used[letter_a] && (r_fill < 5'(pf_pkg::CELLS));
            end
        end
    end

    pf_lane u_lane_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_letter  (letter_a),
        .i_used    (r_used),
        .i_rd_en   (lookup_en),
        .i_place   (place),
        .o_present (present_a),
        .o_loc     (loc_a)
    );

    pf_lane u_lane_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_letter  (letter_b),
        .i_used    (r_used),
        .i_rd_en   (lookup_en),
        .i_place   (place),
        .o_present (present_b),
        .o_loc     (loc_b)
    );

    pf_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_loc_a   (loc_a),
        .i_loc_b   (loc_b),
        .i_decrypt (r_decrypt),
        .i_rd_en   (r_state == S_POS),
        .i_place   (place),
        .o_pair    (pair)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.opcode == pf_pkg::OP_FILL)) begin
                    n_state = S_FILL;
                end else if (lookup_en) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = S_CELL;
            end
            S_CELL: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (r_walk == 5'(pf_pkg::LETTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 5'(pf_pkg::CELLS);
            r_used      <= '1;
            r_walk      <= '0;
            r_decrypt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_decrypt <= i_cfg_wdata;
            end
            if (in_fire && (i_in.opcode == pf_pkg::OP_CLEAR)) begin
                r_used         <= 26'(1) << pf_pkg::IDX_J;
                r_fill         <= '0;
            end else if (place.en) begin
                r_used[place.letter] <= 1'b1;
                r_fill               <= 5'(r_fill + 5'd1);
            end
            if (r_state == S_FILL) begin
                r_walk <= 5'(r_walk + 5'd1);
            end else begin
                r_walk <= '0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup_en) begin
            r_err <= (r_fill < 5'(pf_pkg::CELLS)) || !present_a || !present_b;
        end
        if (load) begin
            r_out_bad    <= r_err;
            r_out_first  <= r_err ? 7'd0 : pf_pkg::CHAR_A + {2'b00, pair.first};
            r_out_second <= r_err ? 7'd0 : pf_pkg::CHAR_A + {2'b00, pair.second};
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.first_out  = r_out_first;
    assign o_out.second_out = r_out_second;
    assign o_out.bad_letter = r_out_bad;

    `PF_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= 5'(pf_pkg::CELLS), "Fill count beyond square size.")
    `PF_ASSERT_IMP(a_j_used, 1'b1, r_used[pf_pkg::IDX_J], "Letter J became placeable.")
    `PF_ASSERT_NEXT(a_fill_end, (r_state == S_FILL) && (r_walk == 5'(pf_pkg::LETTERS - 1)), r_state == S_IDLE, "Fill walk did not end.")
    `PF_ASSERT_IMP(a_bad_zero, r_out_valid && r_out_bad, (r_out_first == 7'd0) && (r_out_second == 7'd0), "Error result carries letters.")

endmodule
`default_nettype wire
